// File: sv/euler_xyz_vector_rotator_core_assert.svh
// Assertion helpers, clocked on aclk, off during reset.
`ifndef EULER_XYZ_VECTOR_ROTATOR_CORE_ASSERT_SVH
`define EULER_XYZ_VECTOR_ROTATOR_CORE_ASSERT_SVH

`define EVR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("assertion failed");

`define EVR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/evr_pkg.sv
package evr_pkg;

    localparam int TRIG_FRAC = 30;
    localparam int TRIG_W    = 32;
    localparam int POLY_W    = 31;

    localparam logic [POLY_W-1:0] TRIG_ONE = 31'd1073741824;
    localparam logic [POLY_W-1:0] K_C1  = 31'd1686629713;
    localparam logic [POLY_W-1:0] K_C3  = 31'd693598668;
    localparam logic [POLY_W-1:0] K_C5  = 31'd85569306;
    localparam logic [POLY_W-1:0] K_C7  = 31'd5026992;
    localparam logic [POLY_W-1:0] K_C9  = 31'd172272;
    localparam logic [POLY_W-1:0] K_C11 = 31'd3864;

    localparam int LANES      = 6;
    localparam int POLY_STEPS = 5;

    typedef logic [POLY_W-1:0] poly_t;
    typedef logic signed [TRIG_W-1:0] trig_t;

    typedef struct packed {
        poly_t f;
        poly_t q;
        poly_t p;
        logic  neg;
    } poly_word_t;

endpackage

// File: sv/euler_xyz_vector_rotator_core.sv
// Throughput: one word per cycle; sine/cosine run through fold and
// square registers, a chain of polynomial cells and an output register
// (8 stages), then one two-stage rotation cell per axis.
// The whole pipe advances together and holds while the output word waits.
// Reset (aresetn, synchronous, active low) clears all valid bits.
`include "euler_xyz_vector_rotator_core_assert.svh"

module euler_xyz_vector_rotator_core #(
    parameter int COORD_BITS = 32,
    parameter int ANGLE_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [COORD_BITS-1:0]  s_point_x,
    input  logic signed [COORD_BITS-1:0]  s_point_y,
    input  logic signed [COORD_BITS-1:0]  s_point_z,
    input  logic [ANGLE_BITS-1:0]         s_turn_about_x,
    input  logic [ANGLE_BITS-1:0]         s_turn_about_y,
    input  logic [ANGLE_BITS-1:0]         s_turn_about_z,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_BITS-1:0]  m_rotated_x,
    output logic signed [COORD_BITS-1:0]  m_rotated_y,
    output logic signed [COORD_BITS-1:0]  m_rotated_z,
    output logic                          m_clipped
);
    import evr_pkg::*;

    localparam int TRIG_LAT = 3 + POLY_STEPS;
    localparam int LAT      = TRIG_LAT + 6;

    localparam poly_t KS [POLY_STEPS] = '{K_C9, K_C7, K_C5, K_C3, K_C1};

    logic                         ce;
    logic [LAT-1:0]               valid_reg;
    logic [LAT-1:0]               valid_next;

    logic [ANGLE_BITS-1:0]        ang [3];
    poly_word_t                   fold_reg [LANES];
    poly_word_t                   sq_reg [LANES];
    poly_word_t                   chain [LANES][POLY_STEPS+1];
    trig_t                        trig_reg [LANES];

    logic signed [COORD_BITS-1:0] cx_reg [TRIG_LAT];
    logic signed [COORD_BITS-1:0] cy_reg [TRIG_LAT];
    logic signed [COORD_BITS-1:0] cz_reg [TRIG_LAT];

    trig_t                        ty_reg [2][2];
    trig_t                        tz_reg [4][2];

    logic signed [COORD_BITS-1:0] x1, y1, z1, x2, y2, z2, x3, y3, z3;
    logic                         clip1, clip2, clip3;

    assign ce      = !m_valid || m_ready;
    assign s_ready = ce;

    assign ang[0] = s_turn_about_x;
    assign ang[1] = s_turn_about_y;
    assign ang[2] = s_turn_about_z;

    always_comb begin
        valid_next = {valid_reg[LAT-2:0], s_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ce) begin
            valid_reg <= valid_next;
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [31:0]        phase;
        logic [1:0]         quad;
        logic [POLY_W-1:0]  low;
        poly_word_t         fold_next;
        poly_word_t         sq_next;
        logic [2*POLY_W-1:0] ff, fp;
        logic [TRIG_W-1:0]  r;
        trig_t              trig_next;

        always_comb begin
            phase = 32'(ang[l/2]) << (32 - ANGLE_BITS);
            quad  = phase[31:30] + 2'(l % 2);
            low   = {1'b0, phase[TRIG_FRAC-1:0]};
            fold_next.f   = quad[0] ? (TRIG_ONE - low) : low;
            fold_next.q   = '0;
            fold_next.p   = K_C11;
            fold_next.neg = quad[1];

            ff = {{POLY_W{1'b0}}, fold_reg[l].f} * {{POLY_W{1'b0}}, fold_reg[l].f};
            sq_next   = fold_reg[l];
            sq_next.q = ff[TRIG_FRAC +: POLY_W];

            fp = {{POLY_W{1'b0}}, chain[l][POLY_STEPS].f}
               * {{POLY_W{1'b0}}, chain[l][POLY_STEPS].p};
            r  = fp[TRIG_FRAC +: TRIG_W];
            if (r > TRIG_W'(TRIG_ONE)) begin
                r = TRIG_W'(TRIG_ONE);
            end
            trig_next = chain[l][POLY_STEPS].neg ? -trig_t'(r) : trig_t'(r);
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                fold_reg[l] <= fold_next;
                sq_reg[l]   <= sq_next;
                trig_reg[l] <= trig_next;
            end
        end

        assign chain[l][0] = sq_reg[l];

        for (genvar k = 0; k < POLY_STEPS; k++) begin : g_step
            evr_poly_cell #(.K(KS[k])) u_cell (
                .aclk  (aclk),
                .ce    (ce),
                .d_in  (chain[l][k]),
                .d_out (chain[l][k+1])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            cx_reg[0] <= s_point_x;
            cy_reg[0] <= s_point_y;
            cz_reg[0] <= s_point_z;
            for (int i = 1; i < TRIG_LAT; i++) begin
                cx_reg[i] <= cx_reg[i-1];
                cy_reg[i] <= cy_reg[i-1];
                cz_reg[i] <= cz_reg[i-1];
            end
            ty_reg[0][0] <= trig_reg[2];
            ty_reg[0][1] <= trig_reg[3];
            ty_reg[1]    <= ty_reg[0];
            tz_reg[0][0] <= trig_reg[4];
            tz_reg[0][1] <= trig_reg[5];
            for (int i = 1; i < 4; i++) begin
                tz_reg[i] <= tz_reg[i-1];
            end
        end
    end

    // lane 2a is sine, 2a+1 cosine
    evr_rot_cell #(.COORD_BITS(COORD_BITS)) u_rot_x (
        .aclk (aclk), .ce (ce),
        .u_in (cy_reg[TRIG_LAT-1]), .v_in (cz_reg[TRIG_LAT-1]), .w_in (cx_reg[TRIG_LAT-1]),
        .cos_in (trig_reg[1]), .sin_in (trig_reg[0]), .clip_in (1'b0),
        .u_out (y1), .v_out (z1), .w_out (x1), .clip_out (clip1)
    );

    evr_rot_cell #(.COORD_BITS(COORD_BITS)) u_rot_y (
        .aclk (aclk), .ce (ce),
        .u_in (z1), .v_in (x1), .w_in (y1),
        .cos_in (ty_reg[1][1]), .sin_in (ty_reg[1][0]), .clip_in (clip1),
        .u_out (z2), .v_out (x2), .w_out (y2), .clip_out (clip2)
    );

    evr_rot_cell #(.COORD_BITS(COORD_BITS)) u_rot_z (
        .aclk (aclk), .ce (ce),
        .u_in (x2), .v_in (y2), .w_in (z2),
        .cos_in (tz_reg[3][1]), .sin_in (tz_reg[3][0]), .clip_in (clip2),
        .u_out (x3), .v_out (y3), .w_out (z3), .clip_out (clip3)
    );

    assign m_valid     = valid_reg[LAT-1];
    assign m_rotated_x = x3;
    assign m_rotated_y = y3;
    assign m_rotated_z = z3;
    assign m_clipped   = clip3;

    `EVR_ASSERT_IMP(a_stall_hold, m_valid && !m_ready, ##1 (m_valid && $stable(m_rotated_x) && $stable(m_rotated_y) && $stable(m_clipped)))
    `EVR_ASSERT_IMP(a_ready_low, !s_ready, m_valid)
    `EVR_ASSERT_IMP(a_sin_range, valid_reg[TRIG_LAT-1], (trig_reg[0] <= trig_t'(TRIG_ONE)) && (trig_reg[0] >= -trig_t'(TRIG_ONE)))
    `EVR_ASSERT_IMP(a_cos_range, valid_reg[TRIG_LAT-1], (trig_reg[5] <= trig_t'(TRIG_ONE)) && (trig_reg[5] >= -trig_t'(TRIG_ONE)))

endmodule

// File: sv/evr_poly_cell.sv
module evr_poly_cell #(
    parameter logic [30:0] K = 31'd0
) (
    input  logic                   aclk,
    input  logic                   ce,
    input  evr_pkg::poly_word_t    d_in,
    output evr_pkg::poly_word_t    d_out
);
    import evr_pkg::*;

    poly_word_t               d_reg;
    poly_word_t               d_next;
    logic [2*POLY_W-1:0]      prod;

    always_comb begin
        prod   = {{POLY_W{1'b0}}, d_in.p} * {{POLY_W{1'b0}}, d_in.q};
        d_next = d_in;
        d_next.p = K - prod[TRIG_FRAC +: POLY_W];
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule

// File: sv/evr_rot_cell.sv
module evr_rot_cell #(
    parameter int COORD_BITS = 32
) (
    input  logic                          aclk,
    input  logic                          ce,
    input  logic signed [COORD_BITS-1:0]  u_in,
    input  logic signed [COORD_BITS-1:0]  v_in,
    input  logic signed [COORD_BITS-1:0]  w_in,
    input  evr_pkg::trig_t                cos_in,
    input  evr_pkg::trig_t                sin_in,
    input  logic                          clip_in,
    output logic signed [COORD_BITS-1:0]  u_out,
    output logic signed [COORD_BITS-1:0]  v_out,
    output logic signed [COORD_BITS-1:0]  w_out,
    output logic                          clip_out
);
    import evr_pkg::*;

    localparam int PW = COORD_BITS + TRIG_W;
    localparam int SW = PW + 1;

    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (TRIG_FRAC - 1);
    localparam logic signed [SW-1:0] HI   = SW'((65'sd1 <<< (COORD_BITS - 1)) - 65'sd1);
    localparam logic signed [SW-1:0] LO   = -HI - SW'(1);

    logic signed [PW-1:0]          uc_reg, vs_reg, vc_reg, us_reg;
    logic signed [COORD_BITS-1:0]  w1_reg;
    logic                          clip1_reg;

    logic signed [COORD_BITS-1:0]  u_reg, v_reg, w_reg;
    logic                          clip_reg;

    logic signed [SW-1:0]          su, sv;
    logic signed [SW-1:0]          ru, rv;
    logic signed [COORD_BITS-1:0]  u_next, v_next;
    logic                          clip_next;

    always_ff @(posedge aclk) begin
        if (ce) begin
            uc_reg    <= PW'(u_in) * PW'(cos_in);
            vs_reg    <= PW'(v_in) * PW'(sin_in);
            vc_reg    <= PW'(v_in) * PW'(cos_in);
            us_reg    <= PW'(u_in) * PW'(sin_in);
            w1_reg    <= w_in;
            clip1_reg <= clip_in;
        end
    end

    always_comb begin
        su = SW'(uc_reg) - SW'(vs_reg) + HALF;
        sv = SW'(vc_reg) + SW'(us_reg) + HALF;
        ru = su >>> TRIG_FRAC;
        rv = sv >>> TRIG_FRAC;
        clip_next = clip1_reg;
        if (ru > HI) begin
            u_next = HI[COORD_BITS-1:0];
            clip_next = 1'b1;
        end else if (ru < LO) begin
            u_next = LO[COORD_BITS-1:0];
            clip_next = 1'b1;
        end else begin
            u_next = ru[COORD_BITS-1:0];
        end
        if (rv > HI) begin
            v_next = HI[COORD_BITS-1:0];
            clip_next = 1'b1;
        end else if (rv < LO) begin
            v_next = LO[COORD_BITS-1:0];
            clip_next = 1'b1;
        end else begin
            v_next = rv[COORD_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            u_reg    <= u_next;
            v_reg    <= v_next;
            w_reg    <= w1_reg;
            clip_reg <= clip_next;
        end
    end

    assign u_out    = u_reg;
    assign v_out    = v_reg;
    assign w_out    = w_reg;
    assign clip_out = clip_reg;

endmodule

// File: tb/sv/euler_xyz_vector_rotator_core_checker.sv
`timescale 1ns / 100ps

module euler_xyz_vector_rotator_core_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [31:0] s_point_x,
    input  logic signed [31:0] s_point_y,
    input  logic signed [31:0] s_point_z,
    input  logic [15:0]        s_turn_about_x,
    input  logic [15:0]        s_turn_about_y,
    input  logic [15:0]        s_turn_about_z,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [31:0] m_rotated_x,
    input  logic signed [31:0] m_rotated_y,
    input  logic signed [31:0] m_rotated_z,
    input  logic               m_clipped,
    output int                 fail_count,
    output int                 pending
);
    import evr_pkg::*;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               clip;
    } rotated_t;

    rotated_t rotated_q[$];
    logic clip_flag;

    assign pending = rotated_q.size();

    function automatic longint floor_shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint quarter_sine(longint unsigned f);
        longint unsigned q, p, r;
        q = (f * f) >> 30;
        p = longint'(K_C11);
        p = longint'(K_C9) - ((p * q) >> 30);
        p = longint'(K_C7) - ((p * q) >> 30);
        p = longint'(K_C5) - ((p * q) >> 30);
        p = longint'(K_C3) - ((p * q) >> 30);
        p = longint'(K_C1) - ((p * q) >> 30);
        r = (f * p) >> 30;
        if (r > 64'd1073741824) r = 64'd1073741824;
        return longint'(r);
    endfunction

    function automatic longint sine_of(logic [31:0] ph);
        longint unsigned f;
        longint m;
        f = ph[29:0];
        if (ph[30]) f = 64'd1073741824 - f;
        m = quarter_sine(f);
        return ph[31] ? -m : m;
    endfunction

    function automatic longint mix(longint a, longint c, longint b, longint t);
        longint ah, al, bh, bl, hi, lo, hq, hr, r, v;
        ah = floor_shr(a, 16); al = a - ah * 65536;
        bh = floor_shr(b, 16); bl = b - bh * 65536;
        hi = ah * c + bh * t;
        lo = al * c + bl * t;
        hq = floor_shr(hi, 14);
        hr = hi - hq * 16384;
        r = hr * 65536 + lo + 64'sd536870912;
        v = hq + floor_shr(r, 30);
        if (v > 64'sd2147483647) begin
            clip_flag = 1'b1;
            v = 64'sd2147483647;
        end else if (v < -64'sd2147483648) begin
            clip_flag = 1'b1;
            v = -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic rotated_t rotate_point(longint x, longint y, longint z,
                                              logic [15:0] ax, logic [15:0] ay,
                                              logic [15:0] az);
        longint c, s, t1, t2;
        rotated_t o;
        clip_flag = 1'b0;
        s = sine_of({ax, 16'h0}); c = sine_of({ax, 16'h0} + 32'h4000_0000);
        t1 = mix(y, c, z, -s); t2 = mix(z, c, y, s); y = t1; z = t2;
        s = sine_of({ay, 16'h0}); c = sine_of({ay, 16'h0} + 32'h4000_0000);
        t1 = mix(z, c, x, -s); t2 = mix(x, c, z, s); z = t1; x = t2;
        s = sine_of({az, 16'h0}); c = sine_of({az, 16'h0} + 32'h4000_0000);
        t1 = mix(x, c, y, -s); t2 = mix(y, c, x, s); x = t1; y = t2;
        o.x = x[31:0]; o.y = y[31:0]; o.z = z[31:0]; o.clip = clip_flag;
        return o;
    endfunction

    always @(posedge aclk) begin
        rotated_t e;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready)
                rotated_q.push_back(rotate_point(s_point_x, s_point_y, s_point_z,
                    s_turn_about_x, s_turn_about_y, s_turn_about_z));
            if (m_valid && m_ready) begin
                if (rotated_q.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10) $display("unexpected output word");
                end else begin
                    e = rotated_q.pop_front();
                    if (e.x !== m_rotated_x || e.y !== m_rotated_y ||
                        e.z !== m_rotated_z || e.clip !== m_clipped) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch exp %0d %0d %0d %b got %0d %0d %0d %b",
                                e.x, e.y, e.z, e.clip, m_rotated_x, m_rotated_y,
                                m_rotated_z, m_clipped);
                    end
                end
            end
        end
    end
endmodule

// File: tb/sv/euler_xyz_vector_rotator_core_tb.sv
`timescale 1ns / 100ps

module euler_xyz_vector_rotator_core_tb;
    logic aclk, aresetn;
    logic s_valid, s_ready, m_valid, m_ready, m_clipped;
    logic signed [31:0] s_point_x, s_point_y, s_point_z;
    logic [15:0] s_turn_about_x, s_turn_about_y, s_turn_about_z;
    logic signed [31:0] m_rotated_x, m_rotated_y, m_rotated_z;
    int fail_count, pending, cycles;
    bit calm, hold_long;

    euler_xyz_vector_rotator_core dut (.*);
    euler_xyz_vector_rotator_core_checker chk (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h3_0000) - 32'h1_8000;
            3: return $urandom_range(0, 32'h200_0000) - 32'h100_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_turn();
        case ($urandom_range(0, 4))
            0: return 16'(16'h4000 * $urandom_range(0, 3));
            1: return 16'(16'h2000 * $urandom_range(0, 7) + $urandom_range(0, 2) - 1);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_word(logic [31:0] x, y, z, logic [15:0] ax, ay, az);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            s_valid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1;
        s_point_x <= x; s_point_y <= y; s_point_z <= z;
        s_turn_about_x <= ax; s_turn_about_y <= ay; s_turn_about_z <= az;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    initial begin
        int gap;
        m_ready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_long) begin
                m_ready <= 0;
                repeat (60) @(negedge aclk);
                hold_long = 0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                gap = $urandom_range(1, 14);
                m_ready <= 0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1;
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 200000) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] ext[4];
        ext = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0};
        calm = 0; hold_long = 0;
        aresetn = 0; s_valid = 0;
        s_point_x = 0; s_point_y = 0; s_point_z = 0;
        s_turn_about_x = 0; s_turn_about_y = 0; s_turn_about_z = 0;
        repeat (5) @(negedge aclk);
        aresetn = 1;
        @(negedge aclk);
        for (int i = 0; i < 4; i++)
            for (int a = 0; a < 4; a++)
                send_word(ext[i], ext[(i + 1) % 4], ext[(i + a) % 4],
                          16'(16'h4000 * a), 16'(16'h2000 * a + 16'h1000),
                          16'(16'hFFFF - a));
        send_word(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h2000, 16'h2000, 16'h2000);
        hold_long = 1;
        for (int i = 0; i < 850; i++) begin
            if (i == 700) calm = 1;
            send_word(pick_coord(), pick_coord(), pick_coord(),
                      pick_turn(), pick_turn(), pick_turn());
        end
        s_valid <= 0;
        while (pending != 0) @(negedge aclk);
        repeat (30) @(negedge aclk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
